// ===== src/cbm_pkg.sv =====
// Shared constants and codes for the cartridge bank mapper bus unit.
// No dependencies; imported by the top level, the checkers and the testbench.
`default_nettype none

package cbm_pkg;

  // Work RAM size in bytes.
  localparam int CBM_RAM_BYTES = 8192;

  // Field widths.
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int ROM_AW   = 20;
  localparam int BANK_W   = 4;
  localparam int LG_W     = 5;
  localparam int SRC_W    = 2;
  localparam int CFG_IW   = 2;

  // Result source codes.
  localparam logic [SRC_W-1:0] SRC_RAM   = 2'd0;
  localparam logic [SRC_W-1:0] SRC_ROM   = 2'd1;
  localparam logic [SRC_W-1:0] SRC_WRITE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_OLD_LAYOUT = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ROM_LG     = 2'd1;

  // Reset values.
  localparam logic [BANK_W-1:0] BANK_RESET  = 4'hF;
  localparam logic [LG_W-1:0]   ROM_LG_RST  = 5'd17;
  localparam logic [LG_W-1:0]   ROM_LG_MIN  = 5'd15;
  localparam logic [LG_W-1:0]   ROM_LG_MAX  = 5'd20;

  // Work RAM window bases in RAM index space.
  localparam logic [ADDR_W-1:0] RAM_OFS_B800 = 16'h0C00;
  localparam logic [ADDR_W-1:0] RAM_OFS_CC00 = 16'h1400;

  // Bank window offsets, new layout and old layout.
  localparam logic [ROM_AW-1:0] OFS_6C00_NEW = 20'h00C00;
  localparam logic [ROM_AW-1:0] OFS_6C00_OLD = 20'h08000;
  localparam logic [ROM_AW-1:0] OFS_7000_NEW = 20'h10000;
  localparam logic [ROM_AW-1:0] OFS_7000_OLD = 20'h00000;
  localparam logic [ROM_AW-1:0] OFS_C000_NEW = 20'h00000;
  localparam logic [ROM_AW-1:0] OFS_C000_OLD = 20'h08400;
  localparam logic [ROM_AW-1:0] FIXED_BASE   = 20'h08000;

endpackage

`default_nettype wire

// ===== src/cbm_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// No dependencies; used for the work RAM of the bank mapper.
`default_nettype none

module cbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds its value when no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/cartridge_bank_mapper_bus_unit.sv =====
// Cartridge bank mapper bus unit: top level of the CPU bus decoder.
// Depends on cbm_pkg and instantiates cbm_ram for the 8 KiB work RAM.
// Each item is one CPU access at $6000-$FFFF and yields exactly one result
// item. Items move through two stages: at the accept edge the address is
// decoded, the work RAM is read or written, the bank registers are loaded
// and the ROM byte address is formed; at the first edge at which the output
// register is free, the registered RAM read data joins the result there.
// The unit accepts one item per cycle while in_stall is low. A RAM write or
// a bank register load is seen by the very next item. The output register
// lets a new item be accepted while a finished result is still waiting, so
// the input stalls only when both the middle stage and the output register
// are full and the output is stalled. Configuration writes are always
// accepted (cfg_ready is held high) and should only be issued while no item
// is in flight. The work RAM holds no defined contents after reset; reading
// a byte that was never written returns an arbitrary value.
`default_nettype none

module cartridge_bank_mapper_bus_unit
  import cbm_pkg::*;
#(
  parameter int RAM_BYTES = CBM_RAM_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input item channel.
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_action,
  input  wire logic [ADDR_W-1:0] in_address,
  input  wire logic [DATA_W-1:0] in_write_data,
  // Result item channel.
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [SRC_W-1:0]  out_source,
  output logic      [DATA_W-1:0] out_read_data,
  output logic      [ROM_AW-1:0] out_rom_address,
  output logic                   out_mirror_horizontal,
  // Configuration write channel.
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [LG_W-1:0]   cfg_data
);

  localparam int RAM_AW = $clog2(RAM_BYTES);

  // Configuration and bank registers.
  logic              old_layout_r, old_layout_nxt;
  logic [LG_W-1:0]   rom_lg_r, rom_lg_nxt;
  logic [BANK_W-1:0] low_bank_r, low_bank_nxt;
  logic [BANK_W-1:0] high_bank_r, high_bank_nxt;

  // Middle stage: waits for the RAM read data.
  logic              s1_valid_r, s1_valid_nxt;
  logic [SRC_W-1:0]  s1_source_r, s1_source_nxt;
  logic [ROM_AW-1:0] s1_rom_r, s1_rom_nxt;
  logic              s1_mirror_r, s1_mirror_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [SRC_W-1:0]  out_source_r, out_source_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [ROM_AW-1:0] out_rom_r, out_rom_nxt;
  logic              out_mirror_r, out_mirror_nxt;

  logic              accept;
  logic              out_free;
  logic              cfg_we;

  // Decode signals.
  logic              hit_ram_a, hit_ram_b, hit_ram_c, ram_hit;
  logic              hit_low, hit_high;
  logic              hit_win_6c, hit_win_70, hit_win_c0;
  logic [ADDR_W-1:0] ram_idx;
  logic [ROM_AW-1:0] hi_ofs, lo_ofs, rom_off, rom_mask;
  logic [LG_W-1:0]   lg_clamped;
  logic              ram_we, ram_re;
  logic [DATA_W-1:0] ram_rdata;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Address decode of the CPU access.
  always_comb begin
    hit_ram_a  = (in_address >= 16'h6000) && (in_address <= 16'h6BFF);
    hit_ram_b  = (in_address >= 16'hB800) && (in_address <= 16'hBFFF);
    hit_ram_c  = (in_address >= 16'hCC00) && (in_address <= 16'hD7FF);
    ram_hit    = hit_ram_a || hit_ram_b || hit_ram_c;
    hit_low    = in_address[15:12] == 4'h8;
    hit_high   = in_address[15:12] == 4'h9;
    hit_win_6c = (in_address >= 16'h6C00) && (in_address <= 16'h6FFF);
    hit_win_70 = in_address[15:12] == 4'h7;
    hit_win_c0 = (in_address >= 16'hC000) && (in_address <= 16'hCBFF);

    if (hit_ram_b) begin
      ram_idx = in_address - 16'hB800 + RAM_OFS_B800;
    end else if (hit_ram_c) begin
      ram_idx = in_address - 16'hCC00 + RAM_OFS_CC00;
    end else begin
      ram_idx = in_address - 16'h6000;
    end
  end

  assign ram_we = accept && in_action && ram_hit;
  assign ram_re = accept && !in_action && ram_hit;

  // ROM byte address for read accesses, using the banks as they stand now.
  always_comb begin
    hi_ofs = {4'd0, high_bank_r, 12'd0};
    lo_ofs = {5'd0, low_bank_r[2:0], 12'd0};
    if (hit_win_6c) begin
      rom_off = {10'd0, in_address[9:0]} + hi_ofs
              + (old_layout_r ? OFS_6C00_OLD : OFS_6C00_NEW);
    end else if (hit_win_70) begin
      rom_off = {8'd0, in_address[11:0]} + lo_ofs
              + (old_layout_r ? OFS_7000_OLD : OFS_7000_NEW);
    end else if (hit_win_c0) begin
      rom_off = {8'd0, in_address[11:0]} + hi_ofs
              + (old_layout_r ? OFS_C000_OLD : OFS_C000_NEW);
    end else begin
      // Last 32 KiB of the ROM; the subtraction wraps under the size mask.
      rom_off = {5'd0, in_address[14:0]} - FIXED_BASE;
    end

    if (rom_lg_r < ROM_LG_MIN) begin
      lg_clamped = ROM_LG_MIN;
    end else if (rom_lg_r > ROM_LG_MAX) begin
      lg_clamped = ROM_LG_MAX;
    end else begin
      lg_clamped = rom_lg_r;
    end
    rom_mask = ~({ROM_AW{1'b1}} << lg_clamped);
  end

  // Register loads, middle stage and output register.
  always_comb begin
    old_layout_nxt = old_layout_r;
    rom_lg_nxt     = rom_lg_r;
    if (cfg_we && cfg_index == CFG_OLD_LAYOUT) begin
      old_layout_nxt = cfg_data[0];
    end else if (cfg_we && cfg_index == CFG_ROM_LG) begin
      rom_lg_nxt = cfg_data;
    end

    low_bank_nxt  = low_bank_r;
    high_bank_nxt = high_bank_r;
    if (accept && in_action && !ram_hit) begin
      if (hit_low) begin
        low_bank_nxt = in_address[BANK_W-1:0];
      end else if (hit_high) begin
        high_bank_nxt = in_address[BANK_W-1:0];
      end
    end

    s1_valid_nxt  = accept || (s1_valid_r && !out_free);
    s1_source_nxt = s1_source_r;
    s1_rom_nxt    = s1_rom_r;
    s1_mirror_nxt = s1_mirror_r;
    if (accept) begin
      s1_mirror_nxt = low_bank_nxt[BANK_W-1];
      if (in_action) begin
        s1_source_nxt = SRC_WRITE;
        s1_rom_nxt    = '0;
      end else if (ram_hit) begin
        s1_source_nxt = SRC_RAM;
        s1_rom_nxt    = '0;
      end else begin
        s1_source_nxt = SRC_ROM;
        s1_rom_nxt    = rom_off & rom_mask;
      end
    end

    out_valid_nxt  = out_valid_r && out_stall;
    out_source_nxt = out_source_r;
    out_data_nxt   = out_data_r;
    out_rom_nxt    = out_rom_r;
    out_mirror_nxt = out_mirror_r;
    if (s1_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_source_nxt = s1_source_r;
      out_data_nxt   = (s1_source_r == SRC_RAM) ? ram_rdata : '0;
      out_rom_nxt    = s1_rom_r;
      out_mirror_nxt = s1_mirror_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_layout_r <= 1'b0;
      rom_lg_r     <= ROM_LG_RST;
      low_bank_r   <= BANK_RESET;
      high_bank_r  <= BANK_RESET;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      old_layout_r <= old_layout_nxt;
      rom_lg_r     <= rom_lg_nxt;
      low_bank_r   <= low_bank_nxt;
      high_bank_r  <= high_bank_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    s1_source_r  <= s1_source_nxt;
    s1_rom_r     <= s1_rom_nxt;
    s1_mirror_r  <= s1_mirror_nxt;
    out_source_r <= out_source_nxt;
    out_data_r   <= out_data_nxt;
    out_rom_r    <= out_rom_nxt;
    out_mirror_r <= out_mirror_nxt;
  end

  cbm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RAM_BYTES)
  ) u_work_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_idx[RAM_AW-1:0]),
    .wdata (in_write_data),
    .rdata (ram_rdata)
  );

  assign out_valid             = out_valid_r;
  assign out_source            = out_source_r;
  assign out_read_data         = out_data_r;
  assign out_rom_address       = out_rom_r;
  assign out_mirror_horizontal = out_mirror_r;

endmodule

`default_nettype wire

// ===== src/cbm_checker.sv =====
// Port-level checker for the cartridge bank mapper bus unit.
// Depends on cbm_pkg; bound to the top level by the statement at the end.
`default_nettype none

module cbm_checker
  import cbm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [SRC_W-1:0]  out_source,
  input wire logic [DATA_W-1:0] out_read_data,
  input wire logic [ROM_AW-1:0] out_rom_address
);

  // A stalled result holds its source, read data and ROM address.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_source)
      && $stable(out_read_data) && $stable(out_rom_address))
    else $error("stalled result changed");

  // Only the three defined sources appear.
  a_src_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_source == SRC_RAM || out_source == SRC_ROM
      || out_source == SRC_WRITE))
    else $error("illegal result source");

  // Fields not selected by the source read as zero.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_source == SRC_RAM || out_read_data == '0)
      && (out_source == SRC_ROM || out_rom_address == '0))
    else $error("unused result field not zero");

  // No result appears in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // The input only stalls while a result is waiting downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind cartridge_bank_mapper_bus_unit cbm_checker u_cbm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_source      (out_source),
  .out_read_data   (out_read_data),
  .out_rom_address (out_rom_address)
);

`default_nettype wire

// ===== dv/mapper_bus_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the cartridge bank mapper bus unit: watches the item, result and
// configuration channels, predicts every result and compares it field by field.
// Depends on cbm_pkg for widths, source codes and register indexes.

module mapper_bus_checker
  import cbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_action,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [SRC_W-1:0]  out_source,
  input  logic [DATA_W-1:0] out_read_data,
  input  logic [ROM_AW-1:0] out_rom_address,
  input  logic              out_mirror_horizontal,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [LG_W-1:0]   cfg_data,
  output int                mismatches,
  output int                pending
);

  typedef struct packed {
    logic [SRC_W-1:0]  source;
    logic [DATA_W-1:0] read_data;
    logic [ROM_AW-1:0] rom_address;
    logic              mirror_horizontal;
  } bus_result_t;

  // Shadow copy of the mapper state.
  logic [DATA_W-1:0] work_ram [CBM_RAM_BYTES];
  logic [BANK_W-1:0] low_bank;
  logic [BANK_W-1:0] high_bank;
  logic              old_layout;
  logic [LG_W-1:0]   rom_lg;

  bus_result_t expected_results[$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  task automatic predict_access(input logic is_write, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] wdata, output bus_result_t res);
    logic [31:0]     ram_slot;
    logic [31:0]     offset;
    logic [31:0]     high_step;
    logic [31:0]     low_step;
    logic [LG_W-1:0] lg;
    bit              hit_ram;
    res = '0;
    res.source = SRC_WRITE;
    ram_slot = 0;
    hit_ram = 1'b1;
    // The three work RAM windows map onto consecutive slices of the RAM.
    if (addr >= 16'h6000 && addr <= 16'h6BFF) ram_slot = 32'(addr - 16'h6000);
    else if (addr >= 16'hB800 && addr <= 16'hBFFF) ram_slot = 32'(addr - 16'hB800) + 32'h0C00;
    else if (addr >= 16'hCC00 && addr <= 16'hD7FF) ram_slot = 32'(addr - 16'hCC00) + 32'h1400;
    else hit_ram = 1'b0;

    if (is_write) begin
      if (hit_ram) work_ram[ram_slot[12:0]] = wdata;
      else if (addr[15:12] == 4'h8) low_bank = addr[3:0];
      else if (addr[15:12] == 4'h9) high_bank = addr[3:0];
    end else if (hit_ram) begin
      res.source = SRC_RAM;
      res.read_data = work_ram[ram_slot[12:0]];
    end else begin
      high_step = {16'd0, high_bank, 12'd0};
      low_step = {17'd0, low_bank[2:0], 12'd0};
      if (addr >= 16'h6C00 && addr <= 16'h6FFF)
        offset = 32'(addr - 16'h6C00) + high_step + (old_layout ? 32'h08000 : 32'h00C00);
      else if (addr >= 16'h7000 && addr <= 16'h7FFF)
        offset = 32'(addr - 16'h7000) + low_step + (old_layout ? 32'h00000 : 32'h10000);
      else if (addr >= 16'hC000 && addr <= 16'hCBFF)
        offset = 32'(addr - 16'hC000) + high_step + (old_layout ? 32'h08400 : 32'h00000);
      else
        // Fixed window: the last 32 KiB, reached by wrapping under the size mask.
        offset = {17'd0, addr[14:0]} - 32'h8000;
      lg = rom_lg;
      if (lg < 5'd15) lg = 5'd15;
      if (lg > 5'd20) lg = 5'd20;
      offset = offset & ((32'd1 << lg) - 32'd1);
      res.source = SRC_ROM;
      res.rom_address = offset[ROM_AW-1:0];
    end
    res.mirror_horizontal = low_bank[3];
  endtask

  always @(posedge clk) begin
    bus_result_t want;
    bus_result_t next_result;
    if (!rst_n) begin
      low_bank = 4'hF;
      high_bank = 4'hF;
      old_layout = 1'b0;
      rom_lg = 5'd17;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_OLD_LAYOUT) old_layout = cfg_data[0];
        else if (cfg_index == CFG_ROM_LG) rom_lg = cfg_data;
      end
      // Results leave before new accesses enter; the block's latency keeps an
      // access from producing its own result at the edge that accepts it.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result item with no access waiting: source %0d rom_address 0x%05h",
                 out_source, out_rom_address);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_source !== want.source) begin
            $error("source: expected %0d, got %0d", want.source, out_source);
            mismatches++;
          end
          if (out_read_data !== want.read_data) begin
            $error("read_data: expected 0x%02h, got 0x%02h", want.read_data, out_read_data);
            mismatches++;
          end
          if (out_rom_address !== want.rom_address) begin
            $error("rom_address: expected 0x%05h, got 0x%05h",
                   want.rom_address, out_rom_address);
            mismatches++;
          end
          if (out_mirror_horizontal !== want.mirror_horizontal) begin
            $error("mirror_horizontal: expected %0d, got %0d",
                   want.mirror_horizontal, out_mirror_horizontal);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_access(in_action, in_address, in_write_data, next_result);
        expected_results.push_back(next_result);
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the cartridge bank mapper bus unit testbench: clock, reset, stimulus and verdict.
// Depends on cbm_pkg, the unit itself and mapper_bus_checker, which does the checking.

module testbench;
  import cbm_pkg::*;

  // Longest run of cycles without any progress before the run is declared hung.
  localparam int HANG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 155;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_action = 1'b0;
  logic [ADDR_W-1:0] in_address = 16'h6000;
  logic [DATA_W-1:0] in_write_data = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SRC_W-1:0]  out_source;
  logic [DATA_W-1:0] out_read_data;
  logic [ROM_AW-1:0] out_rom_address;
  logic              out_mirror_horizontal;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = CFG_OLD_LAYOUT;
  logic [LG_W-1:0]   cfg_data = '0;

  int mismatches;
  int pending;

  // Percent of cycles in which the sender holds back and the receiver stalls.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  int stuck_cycles = 0;

  // The stimulus keeps track of which work RAM bytes have been written, since
  // a read of a byte that was never written has no defined answer.
  bit ram_written [CBM_RAM_BYTES];
  int written_slots[$];

  cartridge_bank_mapper_bus_unit i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_action             (in_action),
    .in_address            (in_address),
    .in_write_data         (in_write_data),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_source            (out_source),
    .out_read_data         (out_read_data),
    .out_rom_address       (out_rom_address),
    .out_mirror_horizontal (out_mirror_horizontal),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  mapper_bus_checker i_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_action             (in_action),
    .in_address            (in_address),
    .in_write_data         (in_write_data),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_source            (out_source),
    .out_read_data         (out_read_data),
    .out_rom_address       (out_rom_address),
    .out_mirror_horizontal (out_mirror_horizontal),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .mismatches            (mismatches),
    .pending               (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver draws a fresh stall decision every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Hang detection: any accepted item, result or register write counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= HANG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Maps a CPU address onto a work RAM byte; returns 0 outside the three windows.
  function automatic bit ram_slot_of(input logic [ADDR_W-1:0] addr, output int slot);
    slot = 0;
    if (addr >= 16'h6000 && addr <= 16'h6BFF) slot = 32'(addr - 16'h6000);
    else if (addr >= 16'hB800 && addr <= 16'hBFFF) slot = 32'(addr - 16'hB800) + 32'h0C00;
    else if (addr >= 16'hCC00 && addr <= 16'hD7FF) slot = 32'(addr - 16'hCC00) + 32'h1400;
    else return 1'b0;
    return 1'b1;
  endfunction

  // The windows together cover the RAM exactly once, so every byte has one address.
  function automatic logic [ADDR_W-1:0] ram_address_of(input int slot);
    if (slot < 32'h0C00) return 16'h6000 + 16'(slot);
    if (slot < 32'h1400) return 16'hB800 + 16'(slot - 32'h0C00);
    return 16'hCC00 + 16'(slot - 32'h1400);
  endfunction

  // Offers one item and returns at the edge that accepts it, with in_valid
  // still high so that the next item can follow back to back.
  task automatic issue_access(input logic is_write, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
    int slot;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= is_write;
    in_address <= addr;
    in_write_data <= data;
    if (is_write && ram_slot_of(addr, slot) && !ram_written[slot]) begin
      ram_written[slot] = 1'b1;
      written_slots.push_back(slot);
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops sending and waits until every result that is owed has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Writes both registers back to back; only called while the unit is idle.
  task automatic program_mapper(input logic layout, input logic [LG_W-1:0] size_lg);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_OLD_LAYOUT;
    cfg_data <= {{(LG_W-1){1'b0}}, layout};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_ROM_LG;
    cfg_data <= size_lg;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random accesses lean toward the interesting windows: RAM traffic with
  // read-back of bytes already written, bank loads and switchable ROM reads,
  // with a tail of fully random accesses across $6000-$FFFF.
  task automatic random_access();
    int               kind;
    int               slot;
    logic             is_write;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    kind = $urandom_range(99);
    data = 8'($urandom);
    is_write = 1'b1;
    if (kind < 30) begin
      addr = ram_address_of($urandom_range(CBM_RAM_BYTES - 1));
    end else if (kind < 55) begin
      if (written_slots.size() == 0) begin
        addr = ram_address_of($urandom_range(CBM_RAM_BYTES - 1));
      end else begin
        is_write = 1'b0;
        addr = ram_address_of(written_slots[$urandom_range(written_slots.size() - 1)]);
      end
    end else if (kind < 70) begin
      addr = 16'h8000 + 16'($urandom_range(16'h1FFF));
    end else if (kind < 90) begin
      is_write = 1'b0;
      case ($urandom_range(2))
        0: addr = 16'h6C00 + 16'($urandom_range(16'h03FF));
        1: addr = 16'h7000 + 16'($urandom_range(16'h0FFF));
        default: addr = 16'hC000 + 16'($urandom_range(16'h0BFF));
      endcase
    end else begin
      is_write = 1'($urandom_range(1));
      addr = 16'($urandom_range(16'hFFFF, 16'h6000));
      // A read of a RAM byte that holds nothing yet becomes a write to it.
      if (!is_write && ram_slot_of(addr, slot) && !ram_written[slot]) is_write = 1'b1;
    end
    issue_access(is_write, addr, data);
  endtask

  initial begin
    logic             phase_layout [6];
    logic [LG_W-1:0]  phase_size_lg [6];
    // Sizes at both ends of the legal range and beyond it on both sides,
    // where the unit must clamp.
    phase_layout = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_size_lg = '{5'd15, 5'd20, 5'd0, 5'd31, 5'd17, 5'd18};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, run with the reset configuration and both banks at 0xF.
    // Fixed-window reads at both ends of the upper range.
    issue_access(1'b0, 16'h8000, 8'h00);
    issue_access(1'b0, 16'hFFFF, 8'hFF);
    // Writes to both ends of every RAM window, then read back.
    issue_access(1'b1, 16'h6000, 8'h00);
    issue_access(1'b1, 16'h6BFF, 8'hFF);
    issue_access(1'b1, 16'hB800, 8'hA5);
    issue_access(1'b1, 16'hBFFF, 8'h5A);
    issue_access(1'b1, 16'hCC00, 8'h3C);
    issue_access(1'b1, 16'hD7FF, 8'hC3);
    issue_access(1'b0, 16'h6000, 8'hFF);
    issue_access(1'b0, 16'h6BFF, 8'h00);
    issue_access(1'b0, 16'hB800, 8'h00);
    issue_access(1'b0, 16'hBFFF, 8'h00);
    issue_access(1'b0, 16'hCC00, 8'h00);
    issue_access(1'b0, 16'hD7FF, 8'h00);
    // Switchable ROM windows with the reset banks.
    issue_access(1'b0, 16'h6C00, 8'h00);
    issue_access(1'b0, 16'h7FFF, 8'h00);
    issue_access(1'b0, 16'hCBFF, 8'h00);
    // Bank loads take the address nibble and ignore the data byte; bit 3 of
    // the low bank turns horizontal mirroring on and off.
    issue_access(1'b1, 16'h8008, 8'hFF);
    issue_access(1'b1, 16'h9000, 8'hFF);
    issue_access(1'b1, 16'h8FF7, 8'h00);
    // Writes into a ROM window and into an unmapped spot are ignored.
    issue_access(1'b1, 16'h7000, 8'h77);
    issue_access(1'b1, 16'hA000, 8'h11);
    // Below $6000: a read falls into the fixed window, a write is dropped.
    issue_access(1'b0, 16'h5FFF, 8'h00);
    issue_access(1'b1, 16'h0000, 8'hEE);

    // Random part in six phases; each starts from an idle unit with a new
    // configuration. Idling runs sender-light/receiver-heavy, then the
    // reverse, then flat out.
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      program_mapper(phase_layout[phase], phase_size_lg[phase]);
      sender_idle_pct = (phase < 2) ? 12 : (phase < 4) ? 46 : 0;
      receiver_stall_pct = (phase < 2) ? 46 : (phase < 4) ? 12 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_access();
      end
    end

    drain_results();
    // Leave a margin for stray results.
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
